FILE: src/acr_pkg.sv
// Package for the ARP cache and responder: beat types, field codes and table sizing.
// No dependencies; every other file in src imports it.
package acr_pkg;

	// Table sizing
	localparam int TABLE_ENTRIES = 16;
	localparam int TBL_IDX_W     = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;

	// Field widths
	localparam int MAC_W = 48;
	localparam int IP_W  = 32;

	// Configuration port
	localparam int APB_ADDR_W = 5;
	localparam int APB_DATA_W = 64;

	// Configuration register indexes (byte address = 8 * index)
	localparam logic [1:0] REG_OWN_MAC      = 2'd0;
	localparam logic [1:0] REG_OWN_IP       = 2'd1;
	localparam logic [1:0] REG_REPLY_ENABLE = 2'd2;

	// Input kinds
	localparam logic [1:0] KIND_RX     = 2'd0;
	localparam logic [1:0] KIND_REQ    = 2'd1;
	localparam logic [1:0] KIND_LOOKUP = 2'd2;
	localparam logic [1:0] KIND_NONE   = 2'd3;

	// Result status codes
	localparam logic [2:0] ST_LEARNED     = 3'd0;
	localparam logic [2:0] ST_BAD_SPACES  = 3'd1;
	localparam logic [2:0] ST_BAD_LENGTHS = 3'd2;
	localparam logic [2:0] ST_BAD_OPCODE  = 3'd3;
	localparam logic [2:0] ST_REQ_BUILT   = 3'd4;
	localparam logic [2:0] ST_LOOKUP_DONE = 3'd5;

	// ARP header constants
	localparam logic [15:0] HW_ETHERNET   = 16'h0001;
	localparam logic [15:0] PROTO_IPV4    = 16'h0800;
	localparam logic [7:0]  HW_LEN_ETH    = 8'd6;
	localparam logic [7:0]  PROTO_LEN_IP4 = 8'd4;
	localparam logic [15:0] OP_REQUEST    = 16'd1;
	localparam logic [15:0] OP_REPLY      = 16'd2;
	localparam logic [1:0]  TX_OP_REQUEST = 2'd1;
	localparam logic [1:0]  TX_OP_REPLY   = 2'd2;

	// Input beat
	typedef struct packed {
		logic [1:0]       kind;
		logic [15:0]      hw_space;
		logic [15:0]      proto_space;
		logic [7:0]       hw_addr_len;
		logic [7:0]       proto_addr_len;
		logic [15:0]      opcode;
		logic [MAC_W-1:0] sender_mac;
		logic [IP_W-1:0]  sender_ip;
		logic [MAC_W-1:0] target_mac;
		logic [IP_W-1:0]  target_ip;
	} acr_in_t;

	// Result beat
	typedef struct packed {
		logic [2:0]       status;
		logic             tx_valid;
		logic [MAC_W-1:0] tx_dest_mac;
		logic [1:0]       tx_opcode;
		logic [MAC_W-1:0] tx_sender_mac;
		logic [IP_W-1:0]  tx_sender_ip;
		logic [MAC_W-1:0] tx_target_mac;
		logic [IP_W-1:0]  tx_target_ip;
		logic             lookup_hit;
		logic [MAC_W-1:0] lookup_mac;
	} acr_out_t;

	// Learn request from the core into the table
	typedef struct packed {
		logic             req;     // item would store sender_ip -> sender_mac
		logic             commit;  // item leaves the input stage this cycle
		logic [IP_W-1:0]  ip;
		logic [MAC_W-1:0] mac;
	} acr_learn_t;

	// Lookup answer, as the table stands after a pending learn
	typedef struct packed {
		logic             hit;
		logic [MAC_W-1:0] mac;
	} acr_tbl_res_t;

endpackage

FILE: src/arp_cache_responder_core.sv
// ARP cache and responder top level: configuration registers, input stage, result
// register and reply/request build. Depends on acr_pkg and acr_table.
//
// Takes one beat per clock through the input register and result register, one
// result per beat except for the unused kind, which is accepted and dropped. The
// table is a 16-entry parallel compare, read and written within the single pass
// from the input register to the result register, so back-to-back beats see every
// earlier learn. Throughput drops only while the result register is held by the
// output side. Configuration (own_mac at 0x00, own_ip at 0x08, reply_enable at
// 0x10) must be written while no beat is in flight. Table entries come up invalid.
module arp_cache_responder_core (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            psel,
	input  logic                            penable,
	input  logic                            pwrite,
	input  logic [acr_pkg::APB_ADDR_W-1:0]  paddr,
	input  logic [acr_pkg::APB_DATA_W-1:0]  pwdata,
	output logic [acr_pkg::APB_DATA_W-1:0]  prdata,
	output logic                            pready,
	input  logic                            in_valid,
	output logic                            in_ready,
	input  acr_pkg::acr_in_t                in_data,
	output logic                            out_valid,
	input  logic                            out_ready,
	output acr_pkg::acr_out_t               out_data
);
	import acr_pkg::*;

	logic [MAC_W-1:0] own_mac_q;
	logic [IP_W-1:0]  own_ip_q;
	logic             reply_enable_q;

	acr_in_t      item_s1;
	logic         valid_s1;
	acr_out_t     res_s2;
	logic         valid_s2;

	logic         advance;
	logic         load;
	logic         cfg_wr;
	logic [1:0]   cfg_idx;
	acr_learn_t   learn;
	acr_tbl_res_t tbl_res;
	acr_out_t     res_d;
	logic         spaces_ok;
	logic         lens_ok;
	logic         op_ok;

	// APB register file
	assign pready  = 1'b1;
	assign cfg_idx = paddr[APB_ADDR_W-1:3];
	assign cfg_wr  = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			own_mac_q      <= '0;
			own_ip_q       <= '0;
			reply_enable_q <= 1'b0;
		end else if (cfg_wr) begin
			case (cfg_idx)
				REG_OWN_MAC:      own_mac_q      <= pwdata[MAC_W-1:0];
				REG_OWN_IP:       own_ip_q       <= pwdata[IP_W-1:0];
				REG_REPLY_ENABLE: reply_enable_q <= pwdata[0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (cfg_idx)
			REG_OWN_MAC:      prdata = APB_DATA_W'(own_mac_q);
			REG_OWN_IP:       prdata = APB_DATA_W'(own_ip_q);
			REG_REPLY_ENABLE: prdata = APB_DATA_W'(reply_enable_q);
			default:          prdata = '0;
		endcase
	end

	// Handshake: input stage moves on when the result register is free or being taken
	assign advance  = valid_s1 && (!valid_s2 || out_ready);
	assign in_ready = !valid_s1 || advance;
	assign load     = in_valid && in_ready && (in_data.kind != KIND_NONE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (load) begin
				valid_s1 <= 1'b1;
			end else if (advance) begin
				valid_s1 <= 1'b0;
			end
			if (advance) begin
				valid_s2 <= 1'b1;
			end else if (out_ready) begin
				valid_s2 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			item_s1 <= in_data;
		end
		if (advance) begin
			res_s2 <= res_d;
		end
	end

	// Header checks for a received packet
	assign spaces_ok = (item_s1.hw_space == HW_ETHERNET) && (item_s1.proto_space == PROTO_IPV4);
	assign lens_ok   = (item_s1.hw_addr_len == HW_LEN_ETH)
	                   && (item_s1.proto_addr_len == PROTO_LEN_IP4);
	assign op_ok     = (item_s1.opcode == OP_REQUEST) || (item_s1.opcode == OP_REPLY);

	assign learn.req    = (item_s1.kind == KIND_RX) && spaces_ok && lens_ok && op_ok;
	assign learn.commit = advance;
	assign learn.ip     = item_s1.sender_ip;
	assign learn.mac    = item_s1.sender_mac;

	acr_table u_table (
		.clk       (clk),
		.arst_n    (arst_n),
		.learn     (learn),
		.lookup_ip (item_s1.target_ip),
		.res       (tbl_res)
	);

	// Result build
	always_comb begin
		res_d = '0;
		case (item_s1.kind)
			KIND_REQ: begin
				res_d.status        = ST_REQ_BUILT;
				res_d.tx_valid      = 1'b1;
				res_d.tx_dest_mac   = '1;
				res_d.tx_opcode     = TX_OP_REQUEST;
				res_d.tx_sender_mac = own_mac_q;
				res_d.tx_sender_ip  = own_ip_q;
				res_d.tx_target_ip  = item_s1.target_ip;
			end
			KIND_LOOKUP: begin
				res_d.status     = ST_LOOKUP_DONE;
				res_d.lookup_hit = tbl_res.hit;
				res_d.lookup_mac = tbl_res.hit ? tbl_res.mac : '0;
			end
			default: begin
				if (!spaces_ok) begin
					res_d.status = ST_BAD_SPACES;
				end else if (!lens_ok) begin
					res_d.status = ST_BAD_LENGTHS;
				end else if (!op_ok) begin
					res_d.status = ST_BAD_OPCODE;
				end else begin
					res_d.status = ST_LEARNED;
					if ((item_s1.opcode == OP_REQUEST) && tbl_res.hit && reply_enable_q) begin
						res_d.tx_valid      = 1'b1;
						res_d.tx_dest_mac   = item_s1.sender_mac;
						res_d.tx_opcode     = TX_OP_REPLY;
						res_d.tx_sender_mac = own_mac_q;
						res_d.tx_sender_ip  = own_ip_q;
						res_d.tx_target_mac = tbl_res.mac;
						res_d.tx_target_ip  = item_s1.target_ip;
					end
				end
			end
		endcase
	end

	assign out_valid = valid_s2;
	assign out_data  = res_s2;

	// Checks
	a_s1_hold: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !advance |=> valid_s1 && $stable(item_s1))
		else $error("input stage lost or changed a stalled beat");

	a_tx_idle_zero: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 && !res_s2.tx_valid |-> (res_s2.tx_dest_mac == '0) && (res_s2.tx_opcode == '0))
		else $error("transmit fields not cleared without a packet");

	a_hit_on_lookup: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 && res_s2.lookup_hit |-> res_s2.status == ST_LOOKUP_DONE)
		else $error("lookup hit reported outside a lookup");

endmodule

FILE: src/acr_table.sv
// IP-keyed ARP table: parallel compare over all entries, learn with in-place update,
// lowest free slot or round-robin replacement. Depends on acr_pkg.
module acr_table (
	input  logic                  clk,
	input  logic                  arst_n,
	input  acr_pkg::acr_learn_t   learn,
	input  logic [acr_pkg::IP_W-1:0] lookup_ip,
	output acr_pkg::acr_tbl_res_t res
);
	import acr_pkg::*;

	logic [IP_W-1:0]          ip_q  [TABLE_ENTRIES];
	logic [MAC_W-1:0]         mac_q [TABLE_ENTRIES];
	logic [TABLE_ENTRIES-1:0] valid_q;
	logic [TBL_IDX_W-1:0]     ptr_q;

	logic [TABLE_ENTRIES-1:0] snd_match;
	logic [TABLE_ENTRIES-1:0] tgt_match;
	logic [TABLE_ENTRIES-1:0] free_vec;
	logic [TABLE_ENTRIES-1:0] free_low;
	logic [TABLE_ENTRIES-1:0] ptr_dec;
	logic [TABLE_ENTRIES-1:0] wr_sel;
	logic [TABLE_ENTRIES-1:0] tgt_keep;
	logic                     snd_hit;
	logic                     full;
	logic                     wr_en;
	logic [MAC_W-1:0]         tgt_mac;

	// Compare both keys against every entry
	always_comb begin
		for (int i = 0; i < TABLE_ENTRIES; i++) begin
			snd_match[i] = valid_q[i] && (ip_q[i] == learn.ip);
			tgt_match[i] = valid_q[i] && (ip_q[i] == lookup_ip);
		end
	end

	// Slot choice: same IP, else lowest free, else replacement pointer
	assign snd_hit  = |snd_match;
	assign full     = &valid_q;
	assign free_vec = ~valid_q;
	assign free_low = free_vec & (~free_vec + TABLE_ENTRIES'(1));
	assign ptr_dec  = TABLE_ENTRIES'(1) << ptr_q;
	assign wr_sel   = snd_hit ? snd_match : (full ? ptr_dec : free_low);
	assign wr_en    = learn.req && learn.commit;

	// Target lookup as seen after the learn; an overwritten entry no longer counts
	assign tgt_keep = tgt_match & ~(learn.req ? wr_sel : '0);

	always_comb begin
		tgt_mac = '0;
		for (int i = 0; i < TABLE_ENTRIES; i++) begin
			if (tgt_keep[i]) begin
				tgt_mac = tgt_mac | mac_q[i];
			end
		end
	end

	always_comb begin
		if (learn.req && (lookup_ip == learn.ip)) begin
			res.hit = 1'b1;
			res.mac = learn.mac;
		end else begin
			res.hit = |tgt_keep;
			res.mac = tgt_mac;
		end
	end

	// Entry payload, no reset
	always_ff @(posedge clk) begin
		for (int i = 0; i < TABLE_ENTRIES; i++) begin
			if (wr_en && wr_sel[i]) begin
				ip_q[i]  <= learn.ip;
				mac_q[i] <= learn.mac;
			end
		end
	end

	// Valid bits and replacement pointer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			ptr_q   <= '0;
		end else if (wr_en) begin
			valid_q <= valid_q | wr_sel;
			if (!snd_hit && full) begin
				if (ptr_q == TBL_IDX_W'(TABLE_ENTRIES - 1)) begin
					ptr_q <= '0;
				end else begin
					ptr_q <= ptr_q + 1'b1;
				end
			end
		end
	end

endmodule

FILE: tb/sv/tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for arp_cache_responder_core: directed and random ARP beats
// checked against an in-bench cache model. Depends on acr_pkg and the core RTL.
module tb;
	import acr_pkg::*;

	localparam int          PHASE_BEATS    = 500;
	localparam int          HOLD_CYCLES    = 300;
	localparam int          SETTLE_CYCLES  = 6;
	localparam int          WATCHDOG_LIMIT = 5000;
	localparam int          POOL_SIZE      = 24;
	localparam logic [47:0] MAC_ONES       = 48'hFFFF_FFFF_FFFF;
	localparam logic [31:0] IP_ONES        = 32'hFFFF_FFFF;

	logic                   clk;
	logic                   arst_n;
	logic                   psel;
	logic                   penable;
	logic                   pwrite;
	logic [APB_ADDR_W-1:0]  paddr;
	logic [APB_DATA_W-1:0]  pwdata;
	logic [APB_DATA_W-1:0]  prdata;
	logic                   pready;
	logic                   in_valid;
	logic                   in_ready;
	acr_in_t                in_data;
	logic                   out_valid;
	logic                   out_ready;
	acr_out_t               out_data;

	arp_cache_responder_core i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.in_data  (in_data),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data (out_data)
	);

	// Cache model state and register shadows
	logic [31:0] cache_ip    [TABLE_ENTRIES];
	logic [47:0] cache_mac   [TABLE_ENTRIES];
	bit          cache_used  [TABLE_ENTRIES];
	int          evict_ptr;
	logic [47:0] shadow_mac;
	logic [31:0] shadow_ip;
	bit          shadow_reply_en;

	acr_out_t    predicted_arp_results[$];
	logic [31:0] ip_pool[POOL_SIZE];

	int errors = 0;
	int reg_errors = 0;
	int n_beats;
	int n_results = 0;
	int n_replies = 0;
	int n_hits = 0;
	int n_drops = 0;
	int n_settings;
	int stall_asked;
	int stall_done;
	bit calm;
	int idle_cycles = 0;

	// Directed vectors
	typedef struct {
		acr_in_t  beat;
		bit       typed;
		acr_out_t want;
	} arp_vec_t;

	arp_vec_t dir_vecs[$];

	// Clock
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Cache model
	function automatic int cache_find(input logic [31:0] ip);
		for (int i = 0; i < TABLE_ENTRIES; i++)
			if (cache_used[i] && cache_ip[i] == ip)
				return i;
		return -1;
	endfunction

	function automatic void cache_learn(input logic [31:0] ip, input logic [47:0] mac);
		int slot;
		slot = cache_find(ip);
		if (slot < 0) begin
			for (int i = 0; i < TABLE_ENTRIES; i++) begin
				if (!cache_used[i]) begin
					slot = i;
					break;
				end
			end
		end
		// full table: round-robin replacement
		if (slot < 0) begin
			slot = evict_ptr;
			evict_ptr = (evict_ptr + 1) % TABLE_ENTRIES;
		end
		cache_ip[slot]   = ip;
		cache_mac[slot]  = mac;
		cache_used[slot] = 1'b1;
	endfunction

	// Returns 1 when the beat produces a result, with that result in r
	function automatic bit arp_predict(input acr_in_t b, output acr_out_t r);
		int slot;
		r = '0;
		case (b.kind)
			KIND_NONE: begin
				return 1'b0;
			end
			KIND_REQ: begin
				r.status        = ST_REQ_BUILT;
				r.tx_valid      = 1'b1;
				r.tx_dest_mac   = MAC_ONES;
				r.tx_opcode     = TX_OP_REQUEST;
				r.tx_sender_mac = shadow_mac;
				r.tx_sender_ip  = shadow_ip;
				r.tx_target_ip  = b.target_ip;
				return 1'b1;
			end
			KIND_LOOKUP: begin
				slot = cache_find(b.target_ip);
				r.status = ST_LOOKUP_DONE;
				if (slot >= 0) begin
					r.lookup_hit = 1'b1;
					r.lookup_mac = cache_mac[slot];
				end
				return 1'b1;
			end
			default: begin
				if (b.hw_space != HW_ETHERNET || b.proto_space != PROTO_IPV4) begin
					r.status = ST_BAD_SPACES;
					return 1'b1;
				end
				if (b.hw_addr_len != HW_LEN_ETH || b.proto_addr_len != PROTO_LEN_IP4) begin
					r.status = ST_BAD_LENGTHS;
					return 1'b1;
				end
				if (b.opcode != OP_REQUEST && b.opcode != OP_REPLY) begin
					r.status = ST_BAD_OPCODE;
					return 1'b1;
				end
				cache_learn(b.sender_ip, b.sender_mac);
				r.status = ST_LEARNED;
				// the entry just learnt may answer its own request
				if (b.opcode == OP_REQUEST) begin
					slot = cache_find(b.target_ip);
					if (slot >= 0 && shadow_reply_en) begin
						r.tx_valid      = 1'b1;
						r.tx_dest_mac   = b.sender_mac;
						r.tx_opcode     = TX_OP_REPLY;
						r.tx_sender_mac = shadow_mac;
						r.tx_sender_ip  = shadow_ip;
						r.tx_target_mac = cache_mac[slot];
						r.tx_target_ip  = b.target_ip;
					end
				end
				return 1'b1;
			end
		endcase
	endfunction

	// Beat builders
	function automatic logic [47:0] rand_mac();
		logic [63:0] w;
		w = {$urandom, $urandom};
		return w[47:0];
	endfunction

	function automatic acr_in_t rx_beat(input logic [15:0] hw, input logic [15:0] proto,
			input logic [7:0] hl, input logic [7:0] pl, input logic [15:0] op,
			input logic [47:0] smac, input logic [31:0] sip, input logic [31:0] tip);
		acr_in_t b;
		b.kind           = KIND_RX;
		b.hw_space       = hw;
		b.proto_space    = proto;
		b.hw_addr_len    = hl;
		b.proto_addr_len = pl;
		b.opcode         = op;
		b.sender_mac     = smac;
		b.sender_ip      = sip;
		b.target_mac     = ~smac;
		b.target_ip      = tip;
		return b;
	endfunction

	function automatic acr_in_t good_rx(input logic [15:0] op, input logic [47:0] smac,
			input logic [31:0] sip, input logic [31:0] tip);
		return rx_beat(HW_ETHERNET, PROTO_IPV4, HW_LEN_ETH, PROTO_LEN_IP4, op, smac, sip, tip);
	endfunction

	function automatic acr_in_t kind_beat(input logic [1:0] kind, input logic [31:0] tip);
		acr_in_t b;
		b           = '0;
		b.kind      = kind;
		b.target_ip = tip;
		return b;
	endfunction

	function automatic acr_out_t status_only(input logic [2:0] st);
		acr_out_t r;
		r        = '0;
		r.status = st;
		return r;
	endfunction

	// Broadcast request as built under the all-ones directed settings
	function automatic acr_out_t bcast_req(input logic [31:0] tip);
		acr_out_t r;
		r               = '0;
		r.status        = ST_REQ_BUILT;
		r.tx_valid      = 1'b1;
		r.tx_dest_mac   = MAC_ONES;
		r.tx_opcode     = TX_OP_REQUEST;
		r.tx_sender_mac = MAC_ONES;
		r.tx_sender_ip  = IP_ONES;
		r.tx_target_ip  = tip;
		return r;
	endfunction

	function automatic void add_vec(input acr_in_t b, input bit typed, input acr_out_t want);
		arp_vec_t v;
		v.beat  = b;
		v.typed = typed;
		v.want  = want;
		dir_vecs.push_back(v);
	endfunction

	function automatic logic [31:0] pick_ip();
		if ($urandom_range(99) < 85)
			return ip_pool[$urandom_range(POOL_SIZE - 1)];
		return $urandom;
	endfunction

	// Mostly well-formed packets over a small IP pool so the table fills and wraps
	function automatic acr_in_t rand_beat();
		acr_in_t      b;
		int           pick;
		logic [255:0] raw;
		pick = $urandom_range(99);
		b = good_rx($urandom_range(1) ? OP_REQUEST : OP_REPLY, rand_mac(), pick_ip(),
			pick_ip());
		b.target_mac = rand_mac();
		if (pick < 50) begin
			return b;
		end else if (pick < 62) begin
			b.kind      = KIND_REQ;
			b.hw_space  = 16'($urandom);
			b.opcode    = 16'($urandom);
			b.target_ip = $urandom_range(1) ? pick_ip() : $urandom;
		end else if (pick < 77) begin
			b.kind = KIND_LOOKUP;
		end else if (pick < 95) begin
			case ($urandom_range(4))
				0: b.hw_space       = 16'($urandom);
				1: b.proto_space    = 16'($urandom);
				2: b.hw_addr_len    = 8'($urandom);
				3: b.proto_addr_len = 8'($urandom);
				default: b.opcode   = 16'($urandom);
			endcase
		end else begin
			raw = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
				$urandom};
			b = raw[$bits(acr_in_t)-1:0];
		end
		return b;
	endfunction

	// Compare one field of a result beat
	task automatic check_field(input string name, input logic [63:0] want,
			input logic [63:0] got);
		if (got !== want) begin
			$error("result field %s: expected 0x%0h, got 0x%0h", name, want, got);
			errors++;
		end
	endtask

	// Result monitor
	always @(posedge clk) begin
		acr_out_t want;
		if (arst_n && out_valid && out_ready) begin
			n_results++;
			if (out_data.tx_valid && out_data.tx_opcode == TX_OP_REPLY)
				n_replies++;
			if (out_data.lookup_hit)
				n_hits++;
			if (out_data.status inside {ST_BAD_SPACES, ST_BAD_LENGTHS, ST_BAD_OPCODE})
				n_drops++;
			if (predicted_arp_results.size() == 0) begin
				$error("result beat with nothing expected: 0x%0h", out_data);
				errors++;
			end else begin
				want = predicted_arp_results.pop_front();
				check_field("status", 64'(want.status), 64'(out_data.status));
				check_field("tx_valid", 64'(want.tx_valid), 64'(out_data.tx_valid));
				check_field("tx_dest_mac", 64'(want.tx_dest_mac),
					64'(out_data.tx_dest_mac));
				check_field("tx_opcode", 64'(want.tx_opcode), 64'(out_data.tx_opcode));
				check_field("tx_sender_mac", 64'(want.tx_sender_mac),
					64'(out_data.tx_sender_mac));
				check_field("tx_sender_ip", 64'(want.tx_sender_ip),
					64'(out_data.tx_sender_ip));
				check_field("tx_target_mac", 64'(want.tx_target_mac),
					64'(out_data.tx_target_mac));
				check_field("tx_target_ip", 64'(want.tx_target_ip),
					64'(out_data.tx_target_ip));
				check_field("lookup_hit", 64'(want.lookup_hit), 64'(out_data.lookup_hit));
				check_field("lookup_mac", 64'(want.lookup_mac), 64'(out_data.lookup_mac));
			end
		end
	end

	// Watchdog on cycles with no beat moving
	always @(posedge clk) begin
		if (!arst_n || (in_valid && in_ready) || (out_valid && out_ready) || psel) begin
			idle_cycles = 0;
		end else begin
			idle_cycles++;
			if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("tb: FAIL");
				$finish;
			end
		end
	end

	// Result side: random back-pressure plus one long hold-off on request
	initial begin
		out_ready <= 1'b0;
		stall_done = 0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			if (stall_asked != stall_done) begin
				out_ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
				stall_done++;
			end else begin
				out_ready <= calm || ($urandom_range(99) >= 27);
				@(posedge clk);
			end
		end
	end

	// Register write over APB, followed by a read-back
	task automatic reg_write(input logic [1:0] idx, input logic [63:0] value,
			input logic [63:0] mask);
		logic [63:0] rd;
		@(posedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 3'b000};
		pwdata  <= value;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		// straight into the read setup
		penable <= 1'b0;
		pwrite  <= 1'b0;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		rd = prdata;
		psel    <= 1'b0;
		penable <= 1'b0;
		if ((rd & mask) !== (value & mask)) begin
			$error("register %0d read-back: expected 0x%0h, got 0x%0h", idx, value & mask,
				rd & mask);
			reg_errors++;
		end
	endtask

	task automatic configure(input logic [47:0] mac, input logic [31:0] ip, input bit en);
		reg_write(REG_OWN_MAC, {16'd0, mac}, {16'd0, MAC_ONES});
		reg_write(REG_OWN_IP, {32'd0, ip}, {32'd0, IP_ONES});
		reg_write(REG_REPLY_ENABLE, {63'd0, en}, 64'd1);
		shadow_mac      = mac;
		shadow_ip       = ip;
		shadow_reply_en = en;
		n_settings++;
	endtask

	// Offer one beat with random leading gaps; returns once it is accepted
	task automatic offer_beat(input acr_in_t b);
		if (!calm)
			while ($urandom_range(99) < 27) begin
				in_valid <= 1'b0;
				@(posedge clk);
			end
		in_valid <= 1'b1;
		in_data  <= b;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		if (b.kind != KIND_NONE)
			n_beats++;
	endtask

	// Predict the accepted beat; typed vectors supply their own expectation
	task automatic log_expectation(input acr_in_t b, input bit typed, input acr_out_t want);
		acr_out_t r;
		if (arp_predict(b, r))
			predicted_arp_results.push_back(typed ? want : r);
	endtask

	// Let everything in flight come out; dropped unused-kind beats have no result to wait for
	task automatic drain();
		in_valid <= 1'b0;
		while (predicted_arp_results.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Stimulus
	initial begin
		acr_in_t b;
		int      sent;
		arst_n      <= 1'b0;
		psel        <= 1'b0;
		penable     <= 1'b0;
		pwrite      <= 1'b0;
		paddr       <= '0;
		pwdata      <= '0;
		in_valid    <= 1'b0;
		in_data     <= '0;
		calm        <= 1'b0;
		stall_asked <= 0;
		n_beats     = 0;
		n_settings  = 0;
		evict_ptr   = 0;
		shadow_mac      = '0;
		shadow_ip       = '0;
		shadow_reply_en = 1'b0;
		for (int i = 0; i < TABLE_ENTRIES; i++)
			cache_used[i] = 1'b0;

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;

		// empty table, unused kind, each drop reason, broadcast requests
		add_vec(kind_beat(KIND_LOOKUP, 32'd0), 1'b1, status_only(ST_LOOKUP_DONE));
		add_vec(kind_beat(KIND_LOOKUP, IP_ONES), 1'b1, status_only(ST_LOOKUP_DONE));
		add_vec('1, 1'b0, '0);
		add_vec(rx_beat(16'd0, PROTO_IPV4, HW_LEN_ETH, PROTO_LEN_IP4, OP_REQUEST, MAC_ONES,
			32'd1, 32'd1), 1'b1, status_only(ST_BAD_SPACES));
		add_vec(rx_beat(16'hFFFF, PROTO_IPV4, HW_LEN_ETH, PROTO_LEN_IP4, OP_REPLY, 48'd0,
			32'd2, 32'd2), 1'b1, status_only(ST_BAD_SPACES));
		add_vec(rx_beat(HW_ETHERNET, 16'hFFFF, HW_LEN_ETH, PROTO_LEN_IP4, OP_REQUEST, 48'd5,
			32'd3, 32'd3), 1'b1, status_only(ST_BAD_SPACES));
		add_vec(rx_beat(HW_ETHERNET, PROTO_IPV4, 8'hFF, PROTO_LEN_IP4, OP_REQUEST, 48'd7,
			32'h0A00_0001, 32'h0A00_0001), 1'b1, status_only(ST_BAD_LENGTHS));
		add_vec(rx_beat(HW_ETHERNET, PROTO_IPV4, HW_LEN_ETH, 8'd0, OP_REPLY, 48'd8,
			32'h0A00_0001, 32'd0), 1'b1, status_only(ST_BAD_LENGTHS));
		add_vec(rx_beat(HW_ETHERNET, PROTO_IPV4, HW_LEN_ETH, 8'd6, OP_REPLY, 48'd9,
			32'h0A00_0001, 32'd0), 1'b1, status_only(ST_BAD_LENGTHS));
		add_vec(good_rx(16'd0, 48'd10, 32'h0A00_0002, 32'd0), 1'b1, status_only(ST_BAD_OPCODE));
		add_vec(good_rx(16'hFFFF, 48'd11, 32'h0A00_0002, 32'd0), 1'b1,
			status_only(ST_BAD_OPCODE));
		add_vec(good_rx(16'd3, 48'd12, 32'h0A00_0002, 32'd0), 1'b1, status_only(ST_BAD_OPCODE));
		// dropped packets must not have been learnt
		add_vec(kind_beat(KIND_LOOKUP, 32'h0A00_0001), 1'b1, status_only(ST_LOOKUP_DONE));
		add_vec(kind_beat(KIND_REQ, 32'd0), 1'b1, bcast_req(32'd0));
		b = '1;
		b.kind = KIND_REQ;
		add_vec(b, 1'b1, bcast_req(IP_ONES));
		// learning, self-answered request, update in place, hits
		add_vec(good_rx(OP_REPLY, 48'd0, 32'd0, IP_ONES), 1'b0, '0);
		add_vec(good_rx(OP_REQUEST, MAC_ONES, IP_ONES, 32'd0), 1'b0, '0);
		add_vec(good_rx(OP_REQUEST, 48'h0123_4567_89AB, 32'hC0A8_0001, 32'hC0A8_0001), 1'b0,
			'0);
		add_vec(good_rx(OP_REQUEST, 48'h0000_0000_0042, 32'hC0A8_0002, 32'hDEAD_BEEF), 1'b0,
			'0);
		add_vec(good_rx(OP_REPLY, 48'h8000_0000_0001, 32'd0, 32'd0), 1'b0, '0);
		add_vec(kind_beat(KIND_LOOKUP, 32'd0), 1'b0, '0);
		add_vec(kind_beat(KIND_LOOKUP, IP_ONES), 1'b0, '0);

		configure(MAC_ONES, IP_ONES, 1'b1);
		foreach (dir_vecs[i]) begin
			offer_beat(dir_vecs[i].beat);
			log_expectation(dir_vecs[i].beat, dir_vecs[i].typed, dir_vecs[i].want);
		end
		drain();

		// Random phases, each under its own register setting
		for (int ph = 0; ph < 4; ph++) begin
			case (ph)
				0: configure(48'd0, 32'd0, 1'b0);
				1: configure(rand_mac(), $urandom, 1'b1);
				2: configure(rand_mac(), $urandom, 1'b0);
				default: configure(MAC_ONES, 32'd0, 1'b1);
			endcase
			foreach (ip_pool[i])
				ip_pool[i] = $urandom;
			// long result-side hold-off while beats keep coming
			if (ph == 0)
				stall_asked <= stall_asked + 1;
			sent = 0;
			while (sent < PHASE_BEATS) begin
				if (ph == 1)
					calm <= (sent >= 150 && sent < 400);
				b = rand_beat();
				offer_beat(b);
				log_expectation(b, 1'b0, '0);
				if (b.kind != KIND_NONE)
					sent++;
			end
			drain();
			calm <= 1'b0;
		end

		$display("tb: %0d beats over %0d register settings, %0d results checked", n_beats,
			n_settings, n_results);
		$display("tb: %0d replies sent, %0d lookup hits, %0d malformed packets dropped",
			n_replies, n_hits, n_drops);
		if (errors == 0 && reg_errors == 0)
			$display("tb: PASS");
		else
			$display("tb: FAIL");
		$finish;
	end

endmodule
